// File: sv/oqpe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ordered queue with positional edit.
// No dependencies; used by the interfaces, the cell and the top level.
package oqpe_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W  = 7;
	localparam int unsigned POS_W  = 7;
	localparam int unsigned REQ_W  = 3;
	localparam int unsigned STAT_W = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_APPEND     = 3'd0,
		REQ_POP_FRONT  = 3'd1,
		REQ_PUSH_FRONT = 3'd2,
		REQ_INSERT_AT  = 3'd3,
		REQ_POP_BACK   = 3'd4,
		REQ_REMOVE_AT  = 3'd5,
		REQ_DUMP       = 3'd6
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_ROTATE
	} cell_op_t;

	// Broadcast to every cell of the row each cycle.
	typedef struct packed {
		cell_op_t            op;
		logic [CNT_W-1:0]    idx;
		logic [DATA_W-1:0]   word;
	} cell_ctl_t;

endpackage

// File: sv/oqpe_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying one queue request per beat.
// Depends on oqpe_pkg for field widths.
interface oqpe_req_if;
	logic                          valid;
	logic                          ready;
	logic [oqpe_pkg::REQ_W-1:0]    req_type;
	logic [oqpe_pkg::POS_W-1:0]    position;
	logic [oqpe_pkg::DATA_W-1:0]   payload;

	modport source (output valid, req_type, position, payload, input ready);
	modport sink (input valid, req_type, position, payload, output ready);
endinterface

// File: sv/oqpe_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: valid/ready handshake carrying one result per beat.
// Depends on oqpe_pkg for field widths.
interface oqpe_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [oqpe_pkg::STAT_W-1:0]   status;
	logic [oqpe_pkg::DATA_W-1:0]   entry_data;
	logic [oqpe_pkg::CNT_W-1:0]    occupancy;
	logic                          last_result;

	modport source (output valid, status, entry_data, occupancy, last_result, input ready);
	modport sink (input valid, status, entry_data, occupancy, last_result, output ready);
endinterface

// File: sv/oqpe_cell.sv
`timescale 1ns / 1ps
// One storage cell of the queue row; holds the entry at a fixed logical index.
// Depends on oqpe_pkg for the broadcast control struct.
module oqpe_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                        clk,
	input  oqpe_pkg::cell_ctl_t         ctl,
	input  logic [oqpe_pkg::DATA_W-1:0] prev_data,
	input  logic [oqpe_pkg::DATA_W-1:0] next_data,
	input  logic [oqpe_pkg::DATA_W-1:0] front_data,
	output logic [oqpe_pkg::DATA_W-1:0] data
);
	import oqpe_pkg::*;

	localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			CELL_WRITE: begin
				if (MY_IDX == ctl.idx) data_d = ctl.word;
			end
			CELL_INSERT: begin
				if (MY_IDX == ctl.idx) data_d = ctl.word;
				else if (MY_IDX > ctl.idx) data_d = prev_data;
			end
			CELL_REMOVE: begin
				if (MY_IDX >= ctl.idx) data_d = next_data;
			end
			CELL_ROTATE: begin
				// idx carries the occupancy; the back cell takes the old front
				if (MY_NEXT == ctl.idx) data_d = front_data;
				else if (MY_NEXT < ctl.idx) data_d = next_data;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

// File: sv/ordered_queue_positional_edit.sv
`timescale 1ns / 1ps
// Ordered queue of 32-bit words with append, pop, positional insert/remove and dump.
// Depends on oqpe_pkg, oqpe_req_if, oqpe_rsp_if and oqpe_cell.
//
// Entries sit in a row of CAPACITY cells with the front in cell 0; every edit
// shifts the affected cells by one toward or away from the front in one step,
// so each request other than dump gives one result beat. A dump of n entries
// gives n beats after the request is taken, one beat per cycle while the output
// register is free or being read, as the row rotates one place per beat through
// the front cell and ends back in order.
// Results pass through one output register; a new request is taken once the previous
// request has handed all its beats to it and the register is free or being read.
module ordered_queue_positional_edit #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	oqpe_req_if.sink   req,
	oqpe_rsp_if.source rsp
);
	import oqpe_pkg::*;

	localparam logic [CNT_W-1:0] CAP_L = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rem_q;
	logic              out_valid_q;
	status_t           status_q;
	logic [DATA_W-1:0] entry_data_q;
	logic [CNT_W-1:0]  occupancy_q;
	logic              last_q;

	logic              out_free;
	logic              out_load;
	logic              req_acc;
	logic              dump_emit;
	logic              full;
	logic              empty;
	logic              ins_pos_ok;
	logic              rem_pos_ok;
	cell_ctl_t         ctl;
	status_t           st_d;
	logic [CNT_W-1:0]  cnt_d;
	logic              go_dump;

	logic [DATA_W-1:0] cell_data [CAPACITY];

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign req_acc   = req.valid && req.ready;
	assign dump_emit = (state_q == S_DUMP) && out_free;
	assign out_load  = dump_emit || (req_acc && !go_dump);

	assign full       = (count_q == CAP_L);
	assign empty      = (count_q == '0);
	assign ins_pos_ok = (req.position != '0) && ({1'b0, req.position} <= ({1'b0, count_q} + 8'd1));
	assign rem_pos_ok = (req.position != '0) && (req.position <= count_q);

	always_comb begin
		ctl.op   = CELL_HOLD;
		ctl.idx  = count_q;
		ctl.word = req.payload;
		st_d     = ST_OK;
		cnt_d    = count_q;
		go_dump  = 1'b0;
		if (dump_emit) begin
			ctl.op  = CELL_ROTATE;
			ctl.idx = count_q;
		end else if (req_acc) begin
			case (req_t'(req.req_type))
				REQ_APPEND: begin
					if (full) st_d = ST_FULL;
					else begin
						ctl.op  = CELL_WRITE;
						ctl.idx = count_q;
						cnt_d   = count_q + ONE;
					end
				end
				REQ_POP_FRONT: begin
					if (empty) st_d = ST_EMPTY;
					else begin
						ctl.op  = CELL_REMOVE;
						ctl.idx = '0;
						cnt_d   = count_q - ONE;
					end
				end
				REQ_PUSH_FRONT: begin
					if (full) st_d = ST_FULL;
					else begin
						ctl.op  = CELL_INSERT;
						ctl.idx = '0;
						cnt_d   = count_q + ONE;
					end
				end
				REQ_INSERT_AT: begin
					if (full) st_d = ST_FULL;
					else if (!ins_pos_ok) st_d = ST_BADPOS;
					else begin
						ctl.op  = CELL_INSERT;
						ctl.idx = req.position - ONE;
						cnt_d   = count_q + ONE;
					end
				end
				REQ_POP_BACK: begin
					if (empty) st_d = ST_EMPTY;
					else cnt_d = count_q - ONE;
				end
				REQ_REMOVE_AT: begin
					if (empty) st_d = ST_EMPTY;
					else if (!rem_pos_ok) st_d = ST_BADPOS;
					else begin
						ctl.op  = CELL_REMOVE;
						ctl.idx = req.position - ONE;
						cnt_d   = count_q - ONE;
					end
				end
				REQ_DUMP: begin
					if (empty) st_d = ST_EMPTY;
					else go_dump = 1'b1;
				end
				default: st_d = ST_OK;
			endcase
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_W-1:0] prev_w;
		logic [DATA_W-1:0] next_w;
		if (g == 0) begin : g_first
			assign prev_w = cell_data[g];
		end else begin : g_mid_prev
			assign prev_w = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign next_w = cell_data[g];
		end else begin : g_mid_next
			assign next_w = cell_data[g+1];
		end
		oqpe_cell #(.IDX(g)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.prev_data  (prev_w),
			.next_data  (next_w),
			.front_data (cell_data[0]),
			.data       (cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rem_q        <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_OK;
			entry_data_q <= '0;
			occupancy_q  <= '0;
			last_q       <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			count_q <= cnt_d;
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (go_dump) begin
							state_q <= S_DUMP;
							rem_q   <= count_q;
						end else begin
							status_q     <= st_d;
							entry_data_q <= '0;
							occupancy_q  <= cnt_d;
							last_q       <= 1'b1;
						end
					end
				end
				S_DUMP: begin
					if (dump_emit) begin
						status_q     <= ST_OK;
						entry_data_q <= cell_data[0];
						occupancy_q  <= count_q;
						last_q       <= (rem_q == ONE);
						rem_q        <= rem_q - ONE;
						if (rem_q == ONE) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.entry_data  = entry_data_q;
	assign rsp.occupancy   = occupancy_q;
	assign rsp.last_result = last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_L)
		else $error("occupancy above capacity");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |-> (count_q != '0) && (rem_q != '0) && (rem_q <= count_q))
		else $error("dump counter out of range");

	a_accept_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> out_valid_q || (state_q == S_DUMP))
		else $error("accepted request produced no beat");

	a_dump_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |=> count_q == $past(count_q))
		else $error("occupancy changed during dump");
`endif

endmodule
